@@ design/ts_pkg.sv @@
// Shared constants and types for the triangle span rasterizer.
// Depends on nothing; used by the channel interfaces and the top level.
`timescale 1ns / 1ps

package ts_pkg;

    // Field widths of the item channels
    localparam int COORD_W = 16;
    localparam int ROW_W   = 10;
    localparam int COL_W   = 11;
    localparam int COLOR_W = 32;

    // Default geometry and slope precision
    localparam int DEF_IMAGE_WIDTH     = 2048;
    localparam int DEF_IMAGE_HEIGHT    = 1024;
    localparam int DEF_SLOPE_FRAC_BITS = 16;

    // Configuration port
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 2;
    localparam logic [REG_IDX_W-1:0] REG_TOP_COLOR    = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_BOTTOM_COLOR = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_SLOPE_LIMIT  = 2'd2;

    localparam logic [COLOR_W-1:0] COLOR_RESET       = 32'hFF00_0000;
    localparam logic [15:0]        SLOPE_LIMIT_RESET = 16'hFFFF;

    // Split-point divider: |a.x*den + dx*dy| stays below 2^34
    localparam int DIV1_NUM_W = 2 * COORD_W + 2;
    localparam int DIV_DEN_W  = COORD_W;

    // One result item
    typedef struct packed {
        logic               span_valid;
        logic [ROW_W-1:0]   span_row;
        logic [COL_W-1:0]   x_first;
        logic [COL_W-1:0]   x_last;
        logic [COLOR_W-1:0] fill_color;
        logic               in_lower_part;
    } t_span;

endpackage

@@ design/ts_tri_if.sv @@
// Input channel: one triangle plus the requested row per item.
// Depends on ts_pkg for field widths.
`timescale 1ns / 1ps

interface ts_tri_if;
    logic                                valid;
    logic                                ready;
    logic signed [ts_pkg::COORD_W-1:0]   vert0_x;
    logic signed [ts_pkg::COORD_W-1:0]   vert0_y;
    logic signed [ts_pkg::COORD_W-1:0]   vert1_x;
    logic signed [ts_pkg::COORD_W-1:0]   vert1_y;
    logic signed [ts_pkg::COORD_W-1:0]   vert2_x;
    logic signed [ts_pkg::COORD_W-1:0]   vert2_y;
    logic        [ts_pkg::ROW_W-1:0]     row;

    modport source (output valid, vert0_x, vert0_y, vert1_x, vert1_y, vert2_x, vert2_y, row,
                    input ready);
    modport sink   (input valid, vert0_x, vert0_y, vert1_x, vert1_y, vert2_x, vert2_y, row,
                    output ready);
endinterface

@@ design/ts_span_if.sv @@
// Output channel: one filled span per item.
// Depends on ts_pkg for field widths.
`timescale 1ns / 1ps

interface ts_span_if;
    logic                          valid;
    logic                          ready;
    logic                          span_valid;
    logic [ts_pkg::ROW_W-1:0]      span_row;
    logic [ts_pkg::COL_W-1:0]      x_first;
    logic [ts_pkg::COL_W-1:0]      x_last;
    logic [ts_pkg::COLOR_W-1:0]    fill_color;
    logic                          in_lower_part;

    modport source (output valid, span_valid, span_row, x_first, x_last, fill_color,
                    in_lower_part, input ready);
    modport sink   (input valid, span_valid, span_row, x_first, x_last, fill_color,
                    in_lower_part, output ready);
endinterface

@@ design/triangle_span_rasterizer.sv @@
// Triangle span rasterizer: one triangle and row in, one span item out.
// Datapath: stages A to C, the split-point divider, stages D1 and D2, the edge-slope dividers
// (bit-per-stage dividers: split-point x, then edge slopes), stages E to G, output register.
// Throughput: one item per cycle; an output register plus one skid entry keep input
// flowing, and the whole pipeline holds only while the skid entry is occupied.
// Reset (synchronous, active low) empties the pipeline and loads register defaults.
`timescale 1ns / 1ps

module triangle_span_rasterizer #(
    parameter int IMAGE_WIDTH     = ts_pkg::DEF_IMAGE_WIDTH,
    parameter int IMAGE_HEIGHT    = ts_pkg::DEF_IMAGE_HEIGHT,
    parameter int SLOPE_FRAC_BITS = ts_pkg::DEF_SLOPE_FRAC_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    ts_tri_if.sink                        i_tri,
    ts_span_if.source                     o_span,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ts_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [ts_pkg::APB_DATA_W-1:0] pwdata,
    output logic [ts_pkg::APB_DATA_W-1:0] prdata,
    output logic                          pready
);

    localparam int CW   = ts_pkg::COORD_W;
    localparam int RW   = ts_pkg::ROW_W;
    localparam int F    = SLOPE_FRAC_BITS;
    localparam int NW1  = ts_pkg::DIV1_NUM_W;
    localparam int DWD  = ts_pkg::DIV_DEN_W;
    localparam int NW2  = CW + F;          // |dx| << F
    localparam int IW   = NW2 + 1;         // signed inverse slope
    localparam int RDW  = CW + 2;          // row - apex.y
    localparam int HB   = IW / 2;          // split of the slope for the product
    localparam int PLW  = HB + 1 + RDW;
    localparam int PHW  = IW - HB + RDW;
    localparam int XW   = IW + RDW + 1;    // edge x in fixed point
    localparam int LPW  = XW - F;
    localparam int PW   = $clog2(IMAGE_WIDTH);
    localparam logic signed [XW-1:0] WMAX = XW'(IMAGE_WIDTH - 1) <<< F;

    typedef struct packed {
        logic signed [CW-1:0] ax;
        logic signed [CW-1:0] ay;
        logic signed [CW-1:0] bx;
        logic signed [CW-1:0] by;
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cy;
        logic [RW-1:0]        row;
        logic                 neg;
    } t_side1;

    typedef struct packed {
        logic signed [CW-1:0] apex_x;
        logic signed [CW-1:0] apex_y;
        logic [RW-1:0]        row;
        logic                 ok;
        logic                 lower;
        logic                 neg1;
    } t_side2;

    // ---------------- configuration registers ----------------
    logic [ts_pkg::COLOR_W-1:0]   r_top_color;
    logic [ts_pkg::COLOR_W-1:0]   r_bottom_color;
    logic [15:0]                  r_slope_limit;
    logic [ts_pkg::REG_IDX_W-1:0] w_reg_idx;

    assign w_reg_idx = paddr[ts_pkg::APB_ADDR_W-1:2];
    assign pready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top_color    <= ts_pkg::COLOR_RESET;
            r_bottom_color <= ts_pkg::COLOR_RESET;
            r_slope_limit  <= ts_pkg::SLOPE_LIMIT_RESET;
        end else if (psel && penable && pwrite) begin
            case (w_reg_idx)
                ts_pkg::REG_TOP_COLOR:    r_top_color    <= pwdata;
                ts_pkg::REG_BOTTOM_COLOR: r_bottom_color <= pwdata;
                ts_pkg::REG_SLOPE_LIMIT:  r_slope_limit  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            ts_pkg::REG_TOP_COLOR:    prdata = r_top_color;
            ts_pkg::REG_BOTTOM_COLOR: prdata = r_bottom_color;
            ts_pkg::REG_SLOPE_LIMIT:  prdata = {16'd0, r_slope_limit};
            default:                  prdata = '0;
        endcase
    end

    // ---------------- pipeline enable and output skid ----------------
    logic         r_skid_valid;
    logic         w_en;
    assign w_en        = !r_skid_valid;
    assign i_tri.ready = w_en;

    // ---------------- stage A: sort by y ----------------
    logic                 r_a_v;
    logic signed [CW-1:0] r_a_ax, r_a_ay, r_a_bx, r_a_by, r_a_cx, r_a_cy;
    logic signed [CW:0]   r_a_den, r_a_dxca, r_a_dyba;
    logic [RW-1:0]        r_a_row;
    logic signed [CW-1:0] n_ax, n_ay, n_bx, n_by, n_cx, n_cy, w_tx, w_ty;

    always_comb begin
        n_ax = i_tri.vert0_x; n_ay = i_tri.vert0_y;
        n_bx = i_tri.vert1_x; n_by = i_tri.vert1_y;
        n_cx = i_tri.vert2_x; n_cy = i_tri.vert2_y;
        w_tx = n_ax; w_ty = n_ay;
        if (n_ay > n_by) begin
            w_tx = n_ax; w_ty = n_ay;
            n_ax = n_bx; n_ay = n_by;
            n_bx = w_tx; n_by = w_ty;
        end
        if (n_by > n_cy) begin
            w_tx = n_bx; w_ty = n_by;
            n_bx = n_cx; n_by = n_cy;
            n_cx = w_tx; n_cy = w_ty;
            if (n_ay > n_by) begin
                w_tx = n_ax; w_ty = n_ay;
                n_ax = n_bx; n_ay = n_by;
                n_bx = w_tx; n_by = w_ty;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (w_en) begin
            r_a_v <= i_tri.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_ax   <= n_ax; r_a_ay <= n_ay;
            r_a_bx   <= n_bx; r_a_by <= n_by;
            r_a_cx   <= n_cx; r_a_cy <= n_cy;
            r_a_den  <= (CW+1)'(n_cy) - (CW+1)'(n_ay);
            r_a_dxca <= (CW+1)'(n_cx) - (CW+1)'(n_ax);
            r_a_dyba <= (CW+1)'(n_by) - (CW+1)'(n_ay);
            r_a_row  <= i_tri.row;
        end
    end

    // ---------------- stage B: split-point products ----------------
    logic                     r_b_v;
    logic signed [2*CW:0]     r_b_m1;
    logic signed [2*CW+1:0]   r_b_m2;
    t_side1                   r_b_side;
    logic signed [2*CW:0]     w_m1;
    logic signed [2*CW+1:0]   w_m2;

    assign w_m1 = r_a_ax * r_a_den;
    assign w_m2 = r_a_dxca * r_a_dyba;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else if (w_en) begin
            r_b_v <= r_a_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b_m1   <= w_m1;
            r_b_m2   <= w_m2;
            r_b_side <= '{ax: r_a_ax, ay: r_a_ay, bx: r_a_bx, by: r_a_by,
                          cx: r_a_cx, cy: r_a_cy, row: r_a_row, neg: 1'b0};
        end
    end

    // ---------------- stage C: numerator, sign and magnitude ----------------
    logic                   r_c_v;
    logic [NW1-1:0]         r_c_num;
    logic [DWD-1:0]         r_c_den;
    t_side1                 r_c_side;
    logic signed [NW1:0]    w_num;
    logic [NW1:0]           w_num_abs;
    t_side1                 w_c_side;

    always_comb begin
        w_num        = (NW1+1)'(r_b_m1) + (NW1+1)'(r_b_m2);
        w_num_abs    = w_num[NW1] ? (NW1+1)'(-w_num) : w_num;
        w_c_side     = r_b_side;
        w_c_side.neg = w_num[NW1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
        end else if (w_en) begin
            r_c_v <= r_b_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c_num  <= w_num_abs[NW1-1:0];
            r_c_den  <= DWD'(r_b_side.cy - r_b_side.ay);
            r_c_side <= w_c_side;
        end
    end

    // ---------------- split-point divider ----------------
    logic           w_d1_v;
    logic [NW1-1:0] w_d1_q;
    logic [$bits(t_side1)-1:0] w_d1_side_bits;
    t_side1         w_d1_side;

    ts_div #(.NW(NW1), .DW(DWD), .SW($bits(t_side1))) u_div_split (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_c_v),
        .i_num   (r_c_num),
        .i_den   (r_c_den),
        .i_side  (r_c_side),
        .o_valid (w_d1_v),
        .o_quo   (w_d1_q),
        .o_side  (w_d1_side_bits)
    );
    assign w_d1_side = t_side1'(w_d1_side_bits);

    // ---------------- stage D1: split x and part selection ----------------
    logic                 r_e1_v;
    logic signed [CW-1:0] r_e1_bx, r_e1_dx, r_e1_by;
    t_side2               r_e1_side;
    logic signed [CW-1:0] w_dx_div, w_dx;
    logic signed [CW:0]   w_r, w_ay, w_by, w_cy;
    logic                 w_up, w_lo, w_ok;

    always_comb begin
        w_dx_div = w_d1_side.neg ? -$signed(w_d1_q[CW-1:0]) : $signed(w_d1_q[CW-1:0]);
        if (w_d1_side.ay == w_d1_side.by) begin
            w_dx = w_d1_side.ax;
        end else if (w_d1_side.by == w_d1_side.cy) begin
            w_dx = w_d1_side.cx;
        end else begin
            w_dx = w_dx_div;
        end
        w_r  = $signed({{(CW+1-RW){1'b0}}, w_d1_side.row});
        w_ay = (CW+1)'(w_d1_side.ay);
        w_by = (CW+1)'(w_d1_side.by);
        w_cy = (CW+1)'(w_d1_side.cy);
        w_up = (w_ay < w_by) && (w_r >= w_ay) && (w_r < w_by);
        w_lo = !w_up && (w_by < w_cy) && (w_r >= w_by) && (w_r <= w_cy);
        w_ok = (w_ay != w_cy) && (32'(w_d1_side.row) < IMAGE_HEIGHT) && (w_up || w_lo);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e1_v <= 1'b0;
        end else if (w_en) begin
            r_e1_v <= w_d1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e1_bx   <= w_d1_side.bx;
            r_e1_by   <= w_d1_side.by;
            r_e1_dx   <= w_dx;
            r_e1_side <= '{apex_x: w_up ? w_d1_side.ax : w_d1_side.cx,
                           apex_y: w_up ? w_d1_side.ay : w_d1_side.cy,
                           row: w_d1_side.row, ok: w_ok, lower: !w_up, neg1: 1'b0};
        end
    end

    // ---------------- stage D2: edge deltas for the slope dividers ----------------
    logic                 r_e2_v;
    logic [NW2-1:0]       r_e2_num1, r_e2_num2;
    logic [DWD-1:0]       r_e2_den;
    logic                 r_e2_neg2;
    t_side2               r_e2_side;
    logic signed [CW-1:0] w_px, w_qx;
    logic signed [CW:0]   w_dx1, w_dx2, w_dy;
    logic [CW:0]          w_adx1, w_adx2, w_ady;
    t_side2               w_e2_side;

    always_comb begin
        w_px   = (r_e1_bx > r_e1_dx) ? r_e1_dx : r_e1_bx;
        w_qx   = (r_e1_bx > r_e1_dx) ? r_e1_bx : r_e1_dx;
        w_dx1  = (CW+1)'(w_px) - (CW+1)'(r_e1_side.apex_x);
        w_dx2  = (CW+1)'(w_qx) - (CW+1)'(r_e1_side.apex_x);
        w_dy   = (CW+1)'(r_e1_by) - (CW+1)'(r_e1_side.apex_y);
        w_adx1 = w_dx1[CW] ? (CW+1)'(-w_dx1) : w_dx1;
        w_adx2 = w_dx2[CW] ? (CW+1)'(-w_dx2) : w_dx2;
        w_ady  = w_dy[CW]  ? (CW+1)'(-w_dy)  : w_dy;
        w_e2_side      = r_e1_side;
        w_e2_side.neg1 = w_dx1[CW] ^ w_dy[CW];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e2_v <= 1'b0;
        end else if (w_en) begin
            r_e2_v <= r_e1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e2_num1 <= {w_adx1[CW-1:0], {F{1'b0}}};
            r_e2_num2 <= {w_adx2[CW-1:0], {F{1'b0}}};
            r_e2_den  <= w_ady[DWD-1:0];
            r_e2_neg2 <= w_dx2[CW] ^ w_dy[CW];
            r_e2_side <= w_e2_side;
        end
    end

    // ---------------- slope dividers, one per edge ----------------
    logic           w_s_v;
    logic           w_s_v2;
    logic [NW2-1:0] w_s_q1, w_s_q2;
    logic [$bits(t_side2)-1:0] w_s_side_bits;
    t_side2         w_s_side;
    logic           w_s_neg2;

    ts_div #(.NW(NW2), .DW(DWD), .SW($bits(t_side2))) u_div_left (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_e2_v),
        .i_num   (r_e2_num1),
        .i_den   (r_e2_den),
        .i_side  (r_e2_side),
        .o_valid (w_s_v),
        .o_quo   (w_s_q1),
        .o_side  (w_s_side_bits)
    );

    ts_div #(.NW(NW2), .DW(DWD), .SW(1)) u_div_right (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_e2_v),
        .i_num   (r_e2_num2),
        .i_den   (r_e2_den),
        .i_side  (r_e2_neg2),
        .o_valid (w_s_v2),
        .o_quo   (w_s_q2),
        .o_side  (w_s_neg2)
    );
    assign w_s_side = t_side2'(w_s_side_bits);

    // ---------------- stage E: signed slopes, steepness, row offset ----------------
    logic                  r_f_v;
    logic signed [IW-1:0]  r_f_inv1, r_f_inv2;
    logic signed [RDW-1:0] r_f_rd;
    logic                  r_f_ok;
    t_side2                r_f_side;
    logic [NW2-1:0]        w_lim;

    assign w_lim = {r_slope_limit, {F{1'b0}}};

    // both edge dividers run in lockstep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_v <= 1'b0;
        end else if (w_en) begin
            r_f_v <= w_s_v && w_s_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f_inv1 <= w_s_side.neg1 ? -$signed({1'b0, w_s_q1}) : $signed({1'b0, w_s_q1});
            r_f_inv2 <= w_s_neg2      ? -$signed({1'b0, w_s_q2}) : $signed({1'b0, w_s_q2});
            r_f_rd   <= $signed({{(RDW-RW){1'b0}}, w_s_side.row}) - RDW'(w_s_side.apex_y);
            r_f_ok   <= w_s_side.ok && (w_s_q1 <= w_lim) && (w_s_q2 <= w_lim);
            r_f_side <= w_s_side;
        end
    end

    // ---------------- stage F: slope times row offset, split in halves ----------------
    logic                  r_g_v;
    logic signed [PLW-1:0] r_g_pl1, r_g_pl2;
    logic signed [PHW-1:0] r_g_ph1, r_g_ph2;
    logic                  r_g_ok;
    t_side2                r_g_side;
    logic signed [HB:0]    w_lo1, w_lo2;
    logic signed [PLW-1:0] w_pl1, w_pl2;
    logic signed [PHW-1:0] w_ph1, w_ph2;

    always_comb begin
        w_lo1 = $signed({1'b0, r_f_inv1[HB-1:0]});
        w_lo2 = $signed({1'b0, r_f_inv2[HB-1:0]});
        w_pl1 = w_lo1 * r_f_rd;
        w_pl2 = w_lo2 * r_f_rd;
        w_ph1 = $signed(r_f_inv1[IW-1:HB]) * r_f_rd;
        w_ph2 = $signed(r_f_inv2[IW-1:HB]) * r_f_rd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_v <= 1'b0;
        end else if (w_en) begin
            r_g_v <= r_f_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_g_pl1  <= w_pl1;
            r_g_pl2  <= w_pl2;
            r_g_ph1  <= w_ph1;
            r_g_ph2  <= w_ph2;
            r_g_ok   <= r_f_ok;
            r_g_side <= r_f_side;
        end
    end

    // ---------------- stage G: edge x in fixed point ----------------
    logic                 r_h_v;
    logic signed [XW-1:0] r_h_x1, r_h_x2;
    logic                 r_h_ok;
    t_side2               r_h_side;
    logic signed [XW-1:0] w_base;

    assign w_base = XW'(r_g_side.apex_x) <<< F;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_v <= 1'b0;
        end else if (w_en) begin
            r_h_v <= r_g_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_h_x1   <= w_base + (XW'(r_g_ph1) <<< HB) + XW'(r_g_pl1);
            r_h_x2   <= w_base + (XW'(r_g_ph2) <<< HB) + XW'(r_g_pl2);
            r_h_ok   <= r_g_ok;
            r_h_side <= r_g_side;
        end
    end

    // ---------------- stage H: clip and form the result item ----------------
    logic [LPW-1:0] w_lo_pix;
    logic [PW-1:0]  w_hi_pix;
    logic           w_below;
    logic           w_hit;
    ts_pkg::t_span  w_res;

    always_comb begin
        w_lo_pix = r_h_x1[XW-1] ? '0 : LPW'(r_h_x1[XW-1:F]);
        // right edge truncates below zero unless it lies within one pixel left of zero
        w_below  = r_h_x2[XW-1] && !((&r_h_x2[XW-1:F]) && (|r_h_x2[F-1:0]));
        if (r_h_x2[XW-1]) begin
            w_hi_pix = '0;
        end else if (r_h_x2 > WMAX) begin
            w_hi_pix = PW'(IMAGE_WIDTH - 1);
        end else begin
            w_hi_pix = r_h_x2[F+PW-1:F];
        end
        w_hit = r_h_ok && !w_below && !(LPW'(w_hi_pix) < w_lo_pix);
        w_res.span_valid    = w_hit;
        w_res.span_row      = r_h_side.row;
        w_res.x_first       = w_hit ? ts_pkg::COL_W'(w_lo_pix) : '0;
        w_res.x_last        = w_hit ? ts_pkg::COL_W'(w_hi_pix) : '0;
        w_res.fill_color    = !w_hit ? '0 :
                              (r_h_side.lower ? r_bottom_color : r_top_color);
        w_res.in_lower_part = w_hit && r_h_side.lower;
    end

    // ---------------- output register and skid entry ----------------
    logic          r_out_valid;
    ts_pkg::t_span r_out, r_skid;
    logic          w_take;

    assign w_take = r_out_valid && o_span.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (r_h_v) begin
            if (r_out_valid && !w_take) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (w_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_take) begin
                r_out <= r_skid;
            end
        end else if (r_h_v) begin
            if (r_out_valid && !w_take) begin
                r_skid <= w_res;
            end else begin
                r_out <= w_res;
            end
        end
    end

    assign o_span.valid         = r_out_valid;
    assign o_span.span_valid    = r_out.span_valid;
    assign o_span.span_row      = r_out.span_row;
    assign o_span.x_first       = r_out.x_first;
    assign o_span.x_last        = r_out.x_last;
    assign o_span.fill_color    = r_out.fill_color;
    assign o_span.in_lower_part = r_out.in_lower_part;

endmodule

@@ design/ts_div.sv @@
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Carries a side payload alongside; stand-alone, no package needed.
`timescale 1ns / 1ps

module ts_div #(
    parameter int NW = 34,
    parameter int DW = 16,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [NW-1:0] o_quo,
    output logic [SW-1:0] o_side
);

    logic          r_valid [NW];
    logic [DW-1:0] r_rem   [NW];
    logic [NW-1:0] r_num   [NW];
    logic [DW-1:0] r_den   [NW];
    logic [SW-1:0] r_side  [NW];

    genvar k;
    for (k = 0; k < NW; k++) begin : g_stage
        logic          p_valid;
        logic [DW-1:0] p_rem;
        logic [NW-1:0] p_num;
        logic [DW-1:0] p_den;
        logic [SW-1:0] p_side;
        logic [DW:0]   w_trial;
        logic          w_take;
        logic [DW-1:0] n_rem;
        logic [NW-1:0] n_num;

        if (k == 0) begin : g_first
            assign p_valid = i_valid;
            assign p_rem   = '0;
            assign p_num   = i_num;
            assign p_den   = i_den;
            assign p_side  = i_side;
        end else begin : g_next
            assign p_valid = r_valid[k-1];
            assign p_rem   = r_rem[k-1];
            assign p_num   = r_num[k-1];
            assign p_den   = r_den[k-1];
            assign p_side  = r_side[k-1];
        end

        // shift in next numerator bit, subtract when it fits
        always_comb begin
            w_trial = {p_rem, p_num[NW-1]};
            w_take  = (w_trial >= {1'b0, p_den});
            n_rem   = w_take ? DW'(w_trial - {1'b0, p_den}) : w_trial[DW-1:0];
            n_num   = {p_num[NW-2:0], w_take};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_valid[k] <= p_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_num[k]  <= n_num;
                r_den[k]  <= p_den;
                r_side[k] <= p_side;
            end
        end
    end

    assign o_valid = r_valid[NW-1];
    assign o_quo   = r_num[NW-1];
    assign o_side  = r_side[NW-1];

endmodule

@@ design/ts_chk.sv @@
// Port-level checks for the triangle span rasterizer, bound to the top level.
// Depends on ts_pkg for field widths.
`timescale 1ns / 1ps

module ts_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_valid,
    input logic                        i_ready,
    input logic                        i_span_valid,
    input logic [ts_pkg::COL_W-1:0]    i_x_first,
    input logic [ts_pkg::COL_W-1:0]    i_x_last,
    input logic [ts_pkg::COLOR_W-1:0]  i_fill_color,
    input logic                        i_in_lower_part
);

    // a waiting item is held until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_ready) |=> i_valid)
        else $error("output item dropped while stalled");

    // an empty span carries zero fields
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_span_valid) |->
            (i_x_first == '0 && i_x_last == '0 && i_fill_color == '0 && !i_in_lower_part))
        else $error("empty span with nonzero fields");

    // a filled span is ordered
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_span_valid) |-> (i_x_first <= i_x_last))
        else $error("span first column past last column");

    // reset leaves no item on the output
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("output item present after reset");

endmodule

bind triangle_span_rasterizer ts_chk u_ts_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (o_span.valid),
    .i_ready         (o_span.ready),
    .i_span_valid    (o_span.span_valid),
    .i_x_first       (o_span.x_first),
    .i_x_last        (o_span.x_last),
    .i_fill_color    (o_span.fill_color),
    .i_in_lower_part (o_span.in_lower_part)
);

@@ tb/sv/tb_triangle_span_rasterizer.sv @@
// Testbench for the triangle span rasterizer: random and directed triangles, in-order span check.
// Depends on ts_pkg, ts_tri_if, ts_span_if and the triangle_span_rasterizer top level.
`timescale 1ns / 1ps

module tb_triangle_span_rasterizer;

    localparam int IMG_W  = 2048;
    localparam int IMG_H  = 1024;
    localparam int FRAC   = 16;
    localparam int LAT    = 58 + FRAC;
    localparam int N_RAND = 700;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic signed [15:0] ax, ay, bx, by, cx, cy;
        logic [9:0]         row;
    } t_tri_req;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [ts_pkg::APB_ADDR_W-1:0] paddr = '0;
    logic [ts_pkg::APB_DATA_W-1:0] pwdata = '0;
    logic [ts_pkg::APB_DATA_W-1:0] prdata;
    logic pready;

    ts_tri_if  tri_ch ();
    ts_span_if span_ch ();

    triangle_span_rasterizer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tri   (tri_ch.sink),
        .o_span  (span_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow registers
    logic [31:0] sh_top_color, sh_bot_color;
    logic [15:0] sh_slope_lim;

    t_tri_req      tri_queue[$];
    ts_pkg::t_span span_queue[$];
    int       n_errors = 0;
    longint   cycle_cnt = 0;
    bit       stim_done = 1'b0;
    bit       send_hold = 1'b1;
    bit       long_stall_req = 1'b0;

    initial forever #2 i_clk = ~i_clk;

    function automatic longint trunc_px(longint v);
        if (v >= 0) return v >>> FRAC;
        return -((-v) >>> FRAC);
    endfunction

    // Span of one part: apex plus the two ends of its flat edge
    function automatic bit part_span(longint apx, longint apy, longint px, longint py,
                                     longint qx, longint qy, longint r,
                                     output longint xf, output longint xl);
        longint t, inv1, inv2, lim, x1, x2, lo, hi, wmax;
        xf = 0;
        xl = 0;
        if (px > qx) begin
            t = px; px = qx; qx = t;
            t = py; py = qy; qy = t;
        end
        if (py == apy || qy == apy) return 0;
        inv1 = ((px - apx) * (64'sd1 <<< FRAC)) / (py - apy);
        inv2 = ((qx - apx) * (64'sd1 <<< FRAC)) / (qy - apy);
        lim = longint'(sh_slope_lim) * (64'sd1 <<< FRAC);
        if ((inv1 < 0 ? -inv1 : inv1) > lim) return 0;
        if ((inv2 < 0 ? -inv2 : inv2) > lim) return 0;
        x1 = apx * (64'sd1 <<< FRAC) + inv1 * (r - apy);
        x2 = apx * (64'sd1 <<< FRAC) + inv2 * (r - apy);
        lo = x1 < 0 ? 0 : (x1 >>> FRAC);
        wmax = longint'(IMG_W - 1) * (64'sd1 <<< FRAC);
        if (x2 > wmax) x2 = wmax;
        hi = trunc_px(x2);
        if (hi < lo) return 0;
        xf = lo;
        xl = hi;
        return 1;
    endfunction

    function automatic ts_pkg::t_span span_of(t_tri_req q);
        longint ax, ay, bx, by, cx, cy, t, r, dx, den, xf, xl;
        ts_pkg::t_span s;
        bit ok;
        ax = q.ax; ay = q.ay; bx = q.bx; by = q.by; cx = q.cx; cy = q.cy;
        r = q.row;
        s = '0;
        s.span_row = q.row;
        ok = 0;
        if (ay > by) begin t = ax; ax = bx; bx = t; t = ay; ay = by; by = t; end
        if (by > cy) begin
            t = bx; bx = cx; cx = t; t = by; by = cy; cy = t;
            if (ay > by) begin t = ax; ax = bx; bx = t; t = ay; ay = by; by = t; end
        end
        if (ay != cy && r < IMG_H) begin
            if (ay == by) dx = ax;
            else if (by == cy) dx = cx;
            else begin
                den = cy - ay;
                dx = (ax * den + (cx - ax) * (by - ay)) / den;
            end
            if (ay < by && r >= ay && r < by) begin
                ok = part_span(ax, ay, bx, by, dx, by, r, xf, xl);
                s.fill_color = sh_top_color;
                s.in_lower_part = 1'b0;
            end else if (by < cy && r >= by && r <= cy) begin
                ok = part_span(cx, cy, bx, by, dx, by, r, xf, xl);
                s.fill_color = sh_bot_color;
                s.in_lower_part = 1'b1;
            end
        end
        if (ok) begin
            s.span_valid = 1'b1;
            s.x_first = xf[10:0];
            s.x_last = xl[10:0];
        end else begin
            s.fill_color = '0;
            s.in_lower_part = 1'b0;
        end
        return s;
    endfunction

    // Register write: setup then access, pready always high
    task automatic reg_write(logic [ts_pkg::REG_IDX_W-1:0] idx, logic [31:0] val);
        @(negedge i_clk);
        psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
        paddr = ts_pkg::APB_ADDR_W'(idx) << 2;
        pwdata = val;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        case (idx)
            ts_pkg::REG_TOP_COLOR:    sh_top_color = val;
            ts_pkg::REG_BOTTOM_COLOR: sh_bot_color = val;
            ts_pkg::REG_SLOPE_LIMIT:  sh_slope_lim = val[15:0];
            default: ;
        endcase
    endtask

    function automatic logic signed [15:0] rnd_coord();
        case ($urandom_range(0, 9))
            0:       return 16'($urandom);
            1:       return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            2, 3:    return 16'($signed($urandom_range(0, 2400)) - 200);
            default: return 16'($urandom_range(0, 1100));
        endcase
    endfunction

    function automatic t_tri_req rnd_tri();
        t_tri_req q;
        q.ax = rnd_coord(); q.ay = rnd_coord();
        q.bx = rnd_coord(); q.by = rnd_coord();
        q.cx = rnd_coord(); q.cy = rnd_coord();
        case ($urandom_range(0, 7))
            0: q.by = q.ay;
            1: q.cy = q.by;
            2: begin q.by = q.ay; q.cy = q.ay; end
            default: ;
        endcase
        // aim the row inside the triangle most of the time
        if ($urandom_range(0, 3) != 0 && q.ay >= 0 && q.ay < 1024)
            q.row = 10'(q.ay + $urandom_range(0, 40));
        else
            q.row = 10'($urandom);
        return q;
    endfunction

    task automatic push_tri(int ax, int ay, int bx, int by, int cx, int cy, int r);
        t_tri_req q;
        q.ax = 16'(ax); q.ay = 16'(ay); q.bx = 16'(bx);
        q.by = 16'(by); q.cx = 16'(cx); q.cy = 16'(cy); q.row = 10'(r);
        tri_queue.insert(tri_queue.size(), q);
    endtask

    task automatic drain();
        while (tri_queue.size() != 0 || span_queue.size() != 0) @(posedge i_clk);
        repeat (LAT + 10) @(posedge i_clk);
    endtask

    // Stimulus and configuration phases
    initial begin
        sh_top_color = ts_pkg::COLOR_RESET;
        sh_bot_color = ts_pkg::COLOR_RESET;
        sh_slope_lim = ts_pkg::SLOPE_LIMIT_RESET;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        reg_write(ts_pkg::REG_TOP_COLOR, 32'hFFFF_FFFF);
        reg_write(ts_pkg::REG_BOTTOM_COLOR, 32'h0000_0000);
        send_hold = 1'b0;

        // directed: normal, flat top, flat bottom, degenerate, clipping, extremes
        push_tri(100, 10, 50, 60, 200, 120, 30);
        push_tri(100, 10, 50, 60, 200, 120, 60);
        push_tri(100, 10, 50, 60, 200, 120, 120);
        push_tri(100, 10, 50, 60, 200, 120, 121);
        push_tri(10, 20, 90, 20, 50, 80, 20);
        push_tri(10, 20, 90, 20, 50, 80, 50);
        push_tri(50, 5, 10, 70, 90, 70, 69);
        push_tri(50, 5, 10, 70, 90, 70, 70);
        push_tri(10, 40, 90, 40, 300, 40, 40);
        push_tri(-500, 0, 3000, 0, 1000, 900, 300);
        push_tri(-32768, -32768, 32767, 32767, 0, 500, 1023);
        push_tri(32767, -32768, -32768, 32767, 32767, 32767, 0);
        push_tri(200, 100, 100, 300, 50, 500, 1023);
        push_tri(0, 0, 2047, 1023, 0, 1023, 1023);
        push_tri(5, 5, 6, 600, 4000, 900, 800);
        drain();

        reg_write(ts_pkg::REG_SLOPE_LIMIT, 32'd0);
        reg_write(ts_pkg::REG_TOP_COLOR, 32'h1234_5678);
        push_tri(10, 10, 10, 100, 10, 200, 50);
        push_tri(10, 10, 60, 100, 10, 200, 50);
        push_tri(-32768, -32768, 32767, 32767, 0, 0, 0);
        drain();

        reg_write(ts_pkg::REG_SLOPE_LIMIT, 32'd2);
        reg_write(ts_pkg::REG_BOTTOM_COLOR, 32'hA5C3_0F69);
        for (int i = 0; i < N_RAND / 3; i++) tri_queue.insert(tri_queue.size(), rnd_tri());
        // long receiver hold-off while items keep coming
        long_stall_req = 1'b1;
        drain();

        reg_write(ts_pkg::REG_SLOPE_LIMIT, 32'h0000_FFFF);
        reg_write(ts_pkg::REG_TOP_COLOR, $urandom);
        for (int i = 0; i < N_RAND / 3; i++) tri_queue.insert(tri_queue.size(), rnd_tri());
        drain();

        reg_write(ts_pkg::REG_SLOPE_LIMIT, 32'($urandom_range(1, 40)));
        reg_write(ts_pkg::REG_BOTTOM_COLOR, $urandom);
        for (int i = 0; i < N_RAND / 3; i++) tri_queue.insert(tri_queue.size(), rnd_tri());
        drain();
        stim_done = 1'b1;
    end

    // Sender: bursts with random gaps
    int burst_left = 0, gap_left = 0;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            tri_ch.valid <= 1'b0;
            tri_ch.vert0_x <= '0; tri_ch.vert0_y <= '0;
            tri_ch.vert1_x <= '0; tri_ch.vert1_y <= '0;
            tri_ch.vert2_x <= '0; tri_ch.vert2_y <= '0;
            tri_ch.row <= '0;
        end else if (!(tri_ch.valid && !tri_ch.ready)) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                tri_ch.valid <= 1'b0;
            end else if (tri_queue.size() > 0 && !send_hold) begin
                tri_ch.valid <= 1'b1;
                tri_ch.vert0_x <= tri_queue[0].ax; tri_ch.vert0_y <= tri_queue[0].ay;
                tri_ch.vert1_x <= tri_queue[0].bx; tri_ch.vert1_y <= tri_queue[0].by;
                tri_ch.vert2_x <= tri_queue[0].cx; tri_ch.vert2_y <= tri_queue[0].cy;
                tri_ch.row <= tri_queue[0].row;
                if (burst_left > 0) burst_left <= burst_left - 1;
                else begin
                    burst_left <= $urandom_range(0, 30);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
            end else begin
                tri_ch.valid <= 1'b0;
            end
        end
    end

    // Acceptance: compute the expected span from the config in force
    always @(posedge i_clk) begin
        if (i_rst_n && tri_ch.valid && tri_ch.ready) begin
            span_queue.insert(span_queue.size(), span_of(tri_queue[0]));
            void'(tri_queue.pop_front());
        end
    end

    // Receiver: stall pattern plus one long hold-off
    int stall_phase = 0, hold_cnt = 0;
    bit hold_done = 1'b0;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            span_ch.ready <= 1'b0;
        end else if (long_stall_req && !hold_done) begin
            span_ch.ready <= 1'b0;
            hold_cnt <= hold_cnt + 1;
            if (hold_cnt >= 300) hold_done <= 1'b1;
        end else begin
            stall_phase <= (stall_phase + 1) % 23;
            if (stall_phase < 8) span_ch.ready <= 1'b1;
            else span_ch.ready <= ($urandom_range(0, 2) != 0);
        end
    end

    // Span checker
    always @(posedge i_clk) begin
        ts_pkg::t_span got, exp_span;
        if (i_rst_n && span_ch.valid && span_ch.ready) begin
            got.span_valid = span_ch.span_valid;
            got.span_row = span_ch.span_row;
            got.x_first = span_ch.x_first;
            got.x_last = span_ch.x_last;
            got.fill_color = span_ch.fill_color;
            got.in_lower_part = span_ch.in_lower_part;
            if (span_queue.size() == 0) begin
                n_errors++;
                $display("%0t unexpected span item %h", $time, got);
            end else begin
                exp_span = span_queue.pop_front();
                if (got !== exp_span) begin
                    n_errors++;
                    $display("%0t span mismatch exp v%0d r%0d %0d..%0d c%h l%0d",
                             $time, exp_span.span_valid, exp_span.span_row,
                             exp_span.x_first, exp_span.x_last, exp_span.fill_color,
                             exp_span.in_lower_part);
                    $display("%0t               got v%0d r%0d %0d..%0d c%h l%0d",
                             $time, got.span_valid, got.span_row, got.x_first,
                             got.x_last, got.fill_color, got.in_lower_part);
                end
            end
        end
    end

    // End of run and timeout
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (stim_done) begin
            if (n_errors == 0 && span_queue.size() == 0)
                $display("tb: success");
            else
                $display("tb: failure");
            $finish;
        end else if (cycle_cnt > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

endmodule
